### rtl/glbs_pkg.sv
// ----------------------------------------------------------------------------
// glbs_pkg
// Shared types and codes for the LED blink scheduler: transaction payloads,
// action and mode codes, and the structs passed between the cells.
// ----------------------------------------------------------------------------
package glbs_pkg;

  localparam int TABLE_ENTRIES_DEF = 50;
  localparam int PIN_COUNT_DEF     = 96;
  localparam int OUT_PIN_BITS      = 50;
  localparam int PIN_W             = 7;
  localparam int ACTION_W          = 3;
  localparam int TIME_W            = 32;
  localparam int MODE_W            = 2;

  localparam logic [ACTION_W-1:0] ACT_SET   = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_READ  = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_BLINK = ACTION_W'(2);
  localparam logic [ACTION_W-1:0] ACT_DRIVE = ACTION_W'(3);
  localparam logic [ACTION_W-1:0] ACT_TICK  = ACTION_W'(4);

  localparam logic [MODE_W-1:0] MODE_IDLE  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_HOLD  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_BLINK = MODE_W'(2);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PIN_W-1:0]    pin;
    logic                level;
    logic                enable;
    logic [TIME_W-1:0]   interval;
    logic [TIME_W-1:0]   now;
  } cmd_t;

  typedef struct packed {
    logic                    status;
    logic                    read_level;
    logic [OUT_PIN_BITS-1:0] blink_pins;
  } res_t;

  // Broadcast write to the table, one cell matches the pin index
  typedef struct packed {
    logic              set_en;
    logic              blink_en;
    logic              drive_en;
    logic [PIN_W-1:0]  pin;
    logic              level;
    logic              enable;
    logic [TIME_W-1:0] interval;
  } cell_cmd_t;

  // Sweep token and its time stamp, handed cell to cell
  typedef struct packed {
    logic              tok;
    logic [TIME_W-1:0] now;
  } sweep_t;

endpackage

### rtl/glbs_cell.sv
// ----------------------------------------------------------------------------
// glbs_cell
// One table entry plus its pin level. Takes broadcast writes addressed to its
// index and services the sweep token once as it passes down the chain.
// ----------------------------------------------------------------------------
module glbs_cell
  import glbs_pkg::*;
#(
  parameter int INDEX     = 0,
  parameter int PIN_COUNT = PIN_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  sweep_t    sweep_in,
  output sweep_t    sweep_out,
  output logic      pin_level
);

  localparam bit HAS_PIN = (INDEX < PIN_COUNT);

  logic [MODE_W-1:0] mode;
  logic              lvl;
  logic [TIME_W-1:0] intv;
  logic [TIME_W-1:0] last;
  logic              pin_q;
  logic              tok;
  logic [TIME_W-1:0] now;
  logic              sel;
  logic [TIME_W-1:0] elapsed;
  logic              expired;

  assign sel     = (cmd.pin == PIN_W'(INDEX));
  assign elapsed = sweep_in.now - last;
  assign expired = (elapsed > intv);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      lvl   <= 1'b0;
      intv  <= '0;
      last  <= '0;
      pin_q <= 1'b0;
      tok   <= 1'b0;
    end else begin
      tok <= sweep_in.tok;
      if (sweep_in.tok && HAS_PIN) begin
        if (mode == MODE_HOLD) begin
          pin_q <= lvl;
        end else if (mode == MODE_BLINK && expired) begin
          pin_q <= ~pin_q;
          last  <= sweep_in.now;
        end
      end
      if (cmd.set_en && sel) begin
        mode <= MODE_HOLD;
        lvl  <= cmd.level;
        intv <= '0;
        last <= '0;
        if (HAS_PIN) begin
          pin_q <= cmd.level;
        end
      end
      if (cmd.blink_en && sel) begin
        mode <= cmd.enable ? MODE_BLINK : MODE_IDLE;
        lvl  <= 1'b0;
        intv <= cmd.interval;
        last <= '0;
      end
      if (cmd.drive_en && sel && HAS_PIN) begin
        pin_q <= cmd.level;
      end
    end
  end

  always_ff @(posedge clk) begin
    now <= sweep_in.now;
  end

  assign sweep_out.tok = tok;
  assign sweep_out.now = now;
  assign pin_level     = HAS_PIN ? pin_q : 1'b0;

endmodule

### rtl/gpio_led_blink_scheduler.sv
// ----------------------------------------------------------------------------
// gpio_led_blink_scheduler
// Output level keeper for PIN_COUNT pins with a hold/blink table covering the
// lowest TABLE_ENTRIES pins, built as a row of entry cells.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Set, read, blink and drive
// actions go from acceptance to ST_FINISH and then to the output register; a
// tick goes through ST_SWEEP first, while the sweep token walks the cell row
// one entry per cycle, each cell doing its own elapsed-time compare as the
// token passes. One item is in flight at a time: cmd_stall is high from the
// cycle after acceptance until the result is loaded into the output register,
// so a new item can be taken while the previous result is still waiting on
// res_stall. The table and all pin levels are cleared by rst; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module gpio_led_blink_scheduler
  import glbs_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int PIN_COUNT     = PIN_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int PIN_SPACE = 1 << PIN_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic                 accept;
  logic [PIN_W-1:0]     pin_q;
  logic                 status_q;
  cell_cmd_t            cell_cmd;
  sweep_t               link [0:TABLE_ENTRIES];
  logic [PIN_SPACE-1:0] pin_all;
  logic                 out_free;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  // broadcast write into the row; only a transaction accepted this cycle
  assign cell_cmd.set_en   = accept && (cmd.action == ACT_SET);
  assign cell_cmd.blink_en = accept && (cmd.action == ACT_BLINK);
  assign cell_cmd.drive_en = accept && (cmd.action == ACT_DRIVE);
  assign cell_cmd.pin      = cmd.pin;
  assign cell_cmd.level    = cmd.level;
  assign cell_cmd.enable   = cmd.enable;
  assign cell_cmd.interval = cmd.interval;

  // a tick injects the token into cell 0 at the acceptance edge
  assign link[0].tok = accept && (cmd.action == ACT_TICK);
  assign link[0].now = cmd.now;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      logic lvl;
      glbs_cell #(
        .INDEX     (gi),
        .PIN_COUNT (PIN_COUNT)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cell_cmd),
        .sweep_in  (link[gi]),
        .sweep_out (link[gi+1]),
        .pin_level (lvl)
      );
    end

    // pin level map over the whole index space: table cells, plain pins above
    // the table, and zero for indices with no pin
    for (gi = 0; gi < PIN_SPACE; gi++) begin : g_pin
      if (gi < TABLE_ENTRIES) begin : g_tab
        assign pin_all[gi] = g_cell[gi].lvl;
      end else if (gi < PIN_COUNT) begin : g_plain
        logic lvl_q;
        always_ff @(posedge clk) begin
          if (rst) begin
            lvl_q <= 1'b0;
          end else if ((cell_cmd.set_en || cell_cmd.drive_en) &&
                       (cmd.pin == PIN_W'(gi))) begin
            lvl_q <= cmd.level;
          end
        end
        assign pin_all[gi] = lvl_q;
      end else begin : g_none
        assign pin_all[gi] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd.action == ACT_TICK) ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (link[TABLE_ENTRIES].tok) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pin_q    <= cmd.pin;
      status_q <= (cmd.action == ACT_BLINK) && (int'(cmd.pin) >= TABLE_ENTRIES);
    end
    if (state == ST_FINISH && out_free) begin
      res.status     <= status_q;
      res.read_level <= pin_all[pin_q];
      res.blink_pins <= pin_all[OUT_PIN_BITS-1:0];
    end
  end

endmodule

### rtl/glbs_checker.sv
// ----------------------------------------------------------------------------
// glbs_checker
// Port-level checks for the LED blink scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module glbs_checker
  import glbs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input cmd_t cmd,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // one transaction in flight: an accepted command closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("input open straight after a transaction");

  // a result only appears while a command is being worked on
  a_res_from_cmd: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_stall))
    else $error("result without a pending command");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

bind gpio_led_blink_scheduler glbs_checker u_glbs_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

### verif/tb_gpio_led_blink_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gpio_led_blink_scheduler
// Self-checking bench for the LED blink scheduler. A short table of directed
// transactions covers the edge cases first: pins past the table and past the
// pin count, rejected blink requests, spare action codes, held pins being
// restored and blink timing across the 2^32 wrap. Around 800 random
// transactions follow, with bursty sending and a changing result-stall
// pattern. Each result is checked against a hand-typed value or a local model of the pin table.
// ----------------------------------------------------------------------------
module tb_gpio_led_blink_scheduler;
  import glbs_pkg::*;

  localparam int TABLE_N       = TABLE_ENTRIES_DEF;
  localparam int PIN_N         = PIN_COUNT_DEF;
  localparam int PIN_MAX       = (1 << PIN_W) - 1;
  localparam int RAND_ITEMS    = 800;
  localparam int SETTLE_CYCLES = TABLE_N + 10;  // a tick sweep plus margin
  localparam int CYCLE_LIMIT   = 400000;

  // Codes 5..7 have no meaning; the block must treat them as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = ACT_TICK + ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = '1;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  // Pins 0 and 49 high, nothing else: the two ends of the table
  localparam logic [OUT_PIN_BITS-1:0] PINS_ENDS =
    (OUT_PIN_BITS'(1) << (TABLE_N - 1)) | OUT_PIN_BITS'(1);

  // Receiver stall styles, picked at random by the result side
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_e;

  // One row of the directed table: the transaction, and an expected result
  // that is typed in by hand when 'typed' is set
  typedef struct packed {
    cmd_t c;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Local copy of the pin table and pin levels; all zero as after reset
  bit [MODE_W-1:0] ent_mode  [TABLE_N];
  bit              ent_level [TABLE_N];
  bit [TIME_W-1:0] ent_ivl   [TABLE_N];
  bit [TIME_W-1:0] ent_last  [TABLE_N];
  bit [PIN_N-1:0]  pin_lvl;

  res_t            expected_q [$];
  stim_row_t       stim_table [$];
  logic [TIME_W-1:0] tick_time = '0;
  int unsigned     cycle_count = 0;
  int unsigned     fail_count  = 0;
  rx_pattern_e     stall_style = RX_FREE;
  int unsigned     stall_span  = 0;

  gpio_led_blink_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Pin table model: applies one transaction, returns the result it gives
  // --------------------------------------------------------------------------
  function automatic res_t step_pin_table(input cmd_t c);
    res_t r;
    int unsigned p;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    p = int'(c.pin);
    case (c.action)
      ACT_SET: begin
        if (p < TABLE_N) begin
          ent_mode[p]  = MODE_HOLD;
          ent_level[p] = c.level;
          ent_ivl[p]   = '0;
          ent_last[p]  = '0;
        end
        if (p < PIN_N) pin_lvl[p] = c.level;
      end
      ACT_BLINK: begin
        if (p < TABLE_N) begin
          ent_ivl[p]   = c.interval;
          ent_last[p]  = '0;
          ent_mode[p]  = c.enable ? MODE_BLINK : MODE_IDLE;
          ent_level[p] = 1'b0;
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_DRIVE: begin
        if (p < PIN_N) pin_lvl[p] = c.level;
      end
      ACT_TICK: begin
        // Sweep from entry 0 up; held pins restored, blinkers toggle once
        // the wrapped elapsed time passes their interval
        for (int i = 0; i < TABLE_N; i++) begin
          if (i >= PIN_N) break;
          if (ent_mode[i] == MODE_HOLD) begin
            pin_lvl[i] = ent_level[i];
          end else if (ent_mode[i] == MODE_BLINK) begin
            elapsed = c.now - ent_last[i];
            if (elapsed > ent_ivl[i]) begin
              pin_lvl[i]  = ~pin_lvl[i];
              ent_last[i] = c.now;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < OUT_PIN_BITS; i++)
      r.blink_pins[i] = (i < PIN_N) ? pin_lvl[i] : 1'b0;
    r.read_level = (p < PIN_N) ? pin_lvl[p] : 1'b0;
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [ACTION_W-1:0] act, input int unsigned pin,
                                  input bit lvl, input bit en,
                                  input logic [TIME_W-1:0] ivl,
                                  input logic [TIME_W-1:0] tnow);
    cmd_t c;
    c.action   = act;
    c.pin      = PIN_W'(pin);
    c.level    = lvl;
    c.enable   = en;
    c.interval = ivl;
    c.now      = tnow;
    return c;
  endfunction

  function automatic res_t mk_res(input bit st, input bit rl,
                                  input logic [OUT_PIN_BITS-1:0] pins);
    res_t r;
    r.status     = st;
    r.read_level = rl;
    r.blink_pins = pins;
    return r;
  endfunction

  // Random transaction. Most pins fall inside the table; intervals are kept
  // short so blinkers actually toggle, and tick time creeps forward with the
  // odd jump, some of them close to the wrap.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned sel;
    int unsigned psel;
    c.level    = 1'($urandom_range(0, 1));
    c.enable   = ($urandom_range(0, 3) != 0);
    c.interval = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
    c.now      = $urandom;
    psel = $urandom_range(0, 9);
    if (psel < 7)      c.pin = PIN_W'($urandom_range(0, TABLE_N - 1));
    else if (psel < 9) c.pin = PIN_W'($urandom_range(TABLE_N, PIN_N - 1));
    else               c.pin = PIN_W'($urandom_range(PIN_N, PIN_MAX));
    sel = $urandom_range(0, 99);
    if (sel < 15)      c.action = ACT_SET;
    else if (sel < 25) c.action = ACT_READ;
    else if (sel < 40) c.action = ACT_BLINK;
    else if (sel < 50) c.action = ACT_DRIVE;
    else if (sel < 95) c.action = ACT_TICK;
    else c.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    if (c.action == ACT_TICK) begin
      case ($urandom_range(0, 15))
        0:       tick_time = $urandom;
        1:       tick_time = TIME_TOP - TIME_W'($urandom_range(0, 30));
        default: tick_time = tick_time + TIME_W'($urandom_range(0, 16));
      endcase
      c.now = tick_time;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: holds the transaction until it is taken, then records the result
  // it should produce. Valid stays high on return so bursts run back to back.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
    res_t predicted;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    predicted = step_pin_table(c);
    expected_q.push_back(typed ? want : predicted);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what,
                                        input logic [OUT_PIN_BITS-1:0] want_v,
                                        input logic [OUT_PIN_BITS-1:0] got_v);
    fail_count++;
    $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern changes at random intervals between none,
  // light random, heavy random and a fixed periodic pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= rx_pattern_e'($urandom_range(RX_FREE, RX_PERIODIC));
      stall_span  <= $urandom_range(50, 400);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      RX_FREE:  res_stall <= 1'b0;
      RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default:  res_stall <= ((cycle_count % 8) < 3);
    endcase
  end

  // Each accepted result transaction is compared with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result, blink_pins", '0, res.blink_pins);
      end else begin
        want = expected_q.pop_front();
        if (res.status !== want.status)
          note_mismatch("status", OUT_PIN_BITS'(want.status), OUT_PIN_BITS'(res.status));
        if (res.read_level !== want.read_level)
          note_mismatch("read_level", OUT_PIN_BITS'(want.read_level),
                        OUT_PIN_BITS'(res.read_level));
        if (res.blink_pins !== want.blink_pins)
          note_mismatch("blink_pins", want.blink_pins, res.blink_pins);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int burst_left;
    int gap;

    // Directed table. Hand-typed results where they are obvious.
    // Fresh from reset everything reads low, including a pin past the count
    stim_table.push_back('{mk_cmd(ACT_READ, 0, 1'b0, 1'b0, '0, '0), 1'b1,
                           mk_res(1'b0, 1'b0, '0)});
    stim_table.push_back('{mk_cmd(ACT_READ, PIN_MAX, 1'b0, 1'b0, '0, '0), 1'b1,
                           mk_res(1'b0, 1'b0, '0)});
    // Hold both ends of the table high
    stim_table.push_back('{mk_cmd(ACT_SET, 0, 1'b1, 1'b0, '0, '0), 1'b1,
                           mk_res(1'b0, 1'b1, OUT_PIN_BITS'(1))});
    stim_table.push_back('{mk_cmd(ACT_SET, TABLE_N - 1, 1'b1, 1'b0, '0, '0), 1'b1,
                           mk_res(1'b0, 1'b1, PINS_ENDS)});
    // First pin without a table entry: level set, not visible in blink_pins
    stim_table.push_back('{mk_cmd(ACT_SET, TABLE_N, 1'b1, 1'b0, '0, '0), 1'b1,
                           mk_res(1'b0, 1'b1, PINS_ENDS)});
    // Blink requests past the table are rejected
    stim_table.push_back('{mk_cmd(ACT_BLINK, TABLE_N, 1'b0, 1'b1, 32'd7, '0), 1'b1,
                           mk_res(1'b1, 1'b1, PINS_ENDS)});
    stim_table.push_back('{mk_cmd(ACT_BLINK, PIN_MAX, 1'b1, 1'b1, TIME_TOP, TIME_TOP),
                           1'b1, mk_res(1'b1, 1'b0, PINS_ENDS)});
    // From here on the model decides
    stim_table.push_back('{mk_cmd(ACT_SET, PIN_N - 1, 1'b1, 1'b0, '0, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_DRIVE, PIN_MAX, 1'b1, 1'b1, '0, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_SET, PIN_N, 1'b1, 1'b0, '0, '0), 1'b0, '0});
    // Blink at both interval extremes, and a disarm
    stim_table.push_back('{mk_cmd(ACT_BLINK, 1, 1'b0, 1'b1, '0, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_BLINK, 2, 1'b0, 1'b1, TIME_TOP, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_BLINK, 3, 1'b1, 1'b0, 32'd5, '0), 1'b0, '0});
    // Knock a held pin low, and raise an idle one; the tick restores the first
    stim_table.push_back('{mk_cmd(ACT_DRIVE, 0, 1'b0, 1'b0, '0, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_DRIVE, 3, 1'b1, 1'b0, '0, '0), 1'b0, '0});
    // Ticks: no elapsed time, one unit, the very top, then wrap back to zero
    stim_table.push_back('{mk_cmd(ACT_TICK, 0, 1'b0, 1'b0, '0, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_TICK, 1, 1'b0, 1'b0, '0, 32'd1), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_TICK, 2, 1'b0, 1'b0, '0, TIME_TOP), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_TICK, 1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
    // Held pin switched to blink keeps its level until it toggles
    stim_table.push_back('{mk_cmd(ACT_BLINK, 0, 1'b1, 1'b1, 32'd3, '0), 1'b0, '0});
    // Spare action codes do nothing
    stim_table.push_back('{mk_cmd(ACT_SPARE_FIRST, 0, 1'b1, 1'b1, TIME_TOP, TIME_TOP),
                           1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_SPARE_LAST, PIN_MAX, 1'b1, 1'b1, TIME_TOP, TIME_TOP),
                           1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_SET, TABLE_N - 1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_TICK, 0, 1'b0, 1'b0, '0, 32'd5), 1'b0, '0});
    stim_table.push_back('{mk_cmd(ACT_READ, PIN_N - 1, 1'b0, 1'b0, '0, '0), 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[k])
      send_cmd(stim_table[k].c, stim_table[k].typed, stim_table[k].want);
    wait_drained();

    // Random part: bursts of 1..24 transactions, a quarter of them with no
    // gap in front, the rest with short or occasionally long gaps
    burst_left = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        wait_drained();
        burst_left = 0;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 7))
          0, 1:    gap = 0;
          2:       gap = $urandom_range(11, 70);
          default: gap = $urandom_range(1, 10);
        endcase
        if (gap != 0) begin
          cmd_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_cmd(rand_cmd(), 1'b0, '0);
      burst_left--;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### gpio_led_blink_scheduler.f
rtl/glbs_pkg.sv
rtl/glbs_cell.sv
rtl/gpio_led_blink_scheduler.sv
rtl/glbs_checker.sv
verif/tb_gpio_led_blink_scheduler.sv
